### hw/rtl/weekly_switch_schedule_matcher_core_defines.svh
// assertion macros for the weekly switch schedule matcher
`ifndef WEEKLY_SWITCH_SCHEDULE_MATCHER_CORE_DEFINES_SVH
`define WEEKLY_SWITCH_SCHEDULE_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define WSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/wssm_pkg.sv
// shared types, constants and helpers of the weekly switch schedule matcher
`timescale 1ns / 1ps

package wssm_pkg;

  localparam int DAYS            = 7;
  localparam int ENTRIES_PER_DAY = 32;
  localparam int MAX_RESULTS     = 16;

  localparam int DEPTH   = DAYS * ENTRIES_PER_DAY;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W   = (ENTRIES_PER_DAY > 1) ? $clog2(ENTRIES_PER_DAY) : 1;
  localparam int CNT_W   = $clog2(ENTRIES_PER_DAY + 1);
  localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
  localparam int DAY_W   = 3;

  typedef logic [1:0]        mode_t;
  typedef logic [DAY_W-1:0]  day_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NRES_W-1:0] nres_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_TICK   = 2'd2;

  typedef struct packed {
    logic [7:0] output_number;
    logic       switch_on;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic addr_t entry_addr(input day_t day, input idx_t idx);
    return addr_t'(int'(day) * ENTRIES_PER_DAY + int'(idx));
  endfunction

endpackage

### hw/rtl/wssm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wssm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 224
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/weekly_switch_schedule_matcher_core.sv
// top level of the weekly switch schedule matcher
// clear and append requests are accepted in idle and need no scan; a tick scans the
// day's entry list, reading the entry ram one entry per cycle while the scan is not stalled
// results may lag by stalls on the result channel; the next request waits for the scan
// synchronous active-low reset empties every day list; entry ram contents are kept
`timescale 1ns / 1ps
`include "weekly_switch_schedule_matcher_core_defines.svh"

module weekly_switch_schedule_matcher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [2:0] in_day,
  input  logic [4:0] in_hour,
  input  logic [5:0] in_minute,
  input  logic [7:0] in_entry_output,
  input  logic       in_entry_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_output_number,
  output logic       out_switch_on,
  output logic       out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                state_r, state_nxt;
  wssm_pkg::cnt_t        cnt_mem_r [wssm_pkg::DAYS];
  wssm_pkg::cnt_t        cnt_mem_nxt [wssm_pkg::DAYS];
  wssm_pkg::day_t        day_r, day_nxt;
  logic [4:0]            hour_r, hour_nxt;
  logic [5:0]            minute_r, minute_nxt;
  wssm_pkg::cnt_t        cnt_r, cnt_nxt;
  wssm_pkg::cnt_t        idx_r, idx_nxt;
  logic                  rvalid_r, rvalid_nxt;
  wssm_pkg::nres_t       nres_r, nres_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [7:0]            pend_output_r, pend_output_nxt;
  logic                  pend_on_r, pend_on_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_output_number_r, out_output_number_nxt;
  logic                  out_switch_on_r, out_switch_on_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we;
  logic                  ram_re;
  wssm_pkg::addr_t       ram_waddr;
  wssm_pkg::addr_t       ram_raddr;
  wssm_pkg::entry_t      ram_wentry;
  logic [wssm_pkg::ENTRY_W-1:0] ram_rdata;
  wssm_pkg::entry_t      rd_entry;

  logic                  day_ok;
  wssm_pkg::cnt_t        in_cnt;
  logic                  out_load_ok;
  logic                  match;
  logic                  stall;

  assign rd_entry    = wssm_pkg::entry_t'(ram_rdata);
  assign day_ok      = (32'(in_day) < wssm_pkg::DAYS);
  assign in_cnt      = day_ok ? cnt_mem_r[in_day] : '0;
  assign out_load_ok = !out_valid_r || out_ready;
  assign match       = rvalid_r && (rd_entry.hour == hour_r) && (rd_entry.minute == minute_r);
  assign stall       = match && pend_valid_r && !out_load_ok;

  assign ram_waddr  = wssm_pkg::entry_addr(in_day, in_cnt[wssm_pkg::IDX_W-1:0]);
  assign ram_raddr  = wssm_pkg::entry_addr(day_r, idx_r[wssm_pkg::IDX_W-1:0]);
  assign ram_wentry = '{output_number: in_entry_output, switch_on: in_entry_on,
                        hour: in_hour, minute: in_minute};

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_output_number = out_output_number_r;
  assign out_switch_on     = out_switch_on_r;
  assign out_last          = out_last_r;

  wssm_ram #(
    .WIDTH(wssm_pkg::ENTRY_W),
    .DEPTH(wssm_pkg::DEPTH)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wentry),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_comb begin
    state_nxt             = state_r;
    cnt_mem_nxt           = cnt_mem_r;
    day_nxt               = day_r;
    hour_nxt              = hour_r;
    minute_nxt            = minute_r;
    cnt_nxt               = cnt_r;
    idx_nxt               = idx_r;
    rvalid_nxt            = rvalid_r;
    nres_nxt              = nres_r;
    pend_valid_nxt        = pend_valid_r;
    pend_output_nxt       = pend_output_r;
    pend_on_nxt           = pend_on_r;
    out_valid_nxt         = out_valid_r;
    out_output_number_nxt = out_output_number_r;
    out_switch_on_nxt     = out_switch_on_r;
    out_last_nxt          = out_last_r;
    ram_we                = 1'b0;
    ram_re                = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            wssm_pkg::MODE_CLEAR: begin
              for (int d = 0; d < wssm_pkg::DAYS; d++) begin
                cnt_mem_nxt[d] = '0;
              end
            end
            wssm_pkg::MODE_APPEND: begin
              if (day_ok && (32'(in_cnt) < wssm_pkg::ENTRIES_PER_DAY)) begin
                ram_we              = 1'b1;
                cnt_mem_nxt[in_day] = in_cnt + 1'b1;
              end
            end
            wssm_pkg::MODE_TICK: begin
              if (day_ok && (in_cnt != '0)) begin
                day_nxt        = in_day;
                hour_nxt       = in_hour;
                minute_nxt     = in_minute;
                cnt_nxt        = in_cnt;
                idx_nxt        = '0;
                rvalid_nxt     = 1'b0;
                nres_nxt       = '0;
                pend_valid_nxt = 1'b0;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (match) begin
            if (pend_valid_r) begin
              out_valid_nxt         = 1'b1;
              out_output_number_nxt = pend_output_r;
              out_switch_on_nxt     = pend_on_r;
              out_last_nxt          = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_output_nxt = rd_entry.output_number;
            pend_on_nxt     = rd_entry.switch_on;
            nres_nxt        = nres_r + 1'b1;
          end
          if (match && (nres_r == wssm_pkg::nres_t'(wssm_pkg::MAX_RESULTS - 1))) begin
            rvalid_nxt = 1'b0;
            state_nxt  = ST_FLUSH;
          end else if (idx_r < cnt_r) begin
            ram_re     = 1'b1;
            idx_nxt    = idx_r + 1'b1;
            rvalid_nxt = 1'b1;
          end else begin
            rvalid_nxt = 1'b0;
            state_nxt  = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_load_ok) begin
          out_valid_nxt         = 1'b1;
          out_output_number_nxt = pend_output_r;
          out_switch_on_nxt     = pend_on_r;
          out_last_nxt          = 1'b1;
          pend_valid_nxt        = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rvalid_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      nres_r       <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      for (int d = 0; d < wssm_pkg::DAYS; d++) begin
        cnt_mem_r[d] <= '0;
      end
    end else begin
      state_r             <= state_nxt;
      rvalid_r            <= rvalid_nxt;
      pend_valid_r        <= pend_valid_nxt;
      out_valid_r         <= out_valid_nxt;
      nres_r              <= nres_nxt;
      idx_r               <= idx_nxt;
      cnt_r               <= cnt_nxt;
      cnt_mem_r           <= cnt_mem_nxt;
      day_r               <= day_nxt;
      hour_r              <= hour_nxt;
      minute_r            <= minute_nxt;
      pend_output_r       <= pend_output_nxt;
      pend_on_r           <= pend_on_nxt;
      out_output_number_r <= out_output_number_nxt;
      out_switch_on_r     <= out_switch_on_nxt;
      out_last_r          <= out_last_nxt;
    end
  end

  `WSSM_ASSERT_NOW(a_idle_no_pending, state_r == ST_IDLE, !pend_valid_r, "pending result left in idle")
  `WSSM_ASSERT_NOW(a_scan_idx_bound, state_r == ST_SCAN, idx_r <= cnt_r, "scan index past list end")
  `WSSM_ASSERT_NOW(a_result_bound, 1'b1, 32'(nres_r) <= wssm_pkg::MAX_RESULTS, "too many results")
  `WSSM_ASSERT_NEXT(a_flush_last, (state_r == ST_FLUSH) && pend_valid_r && out_load_ok, out_valid_r && out_last_r, "final result not marked last")

endmodule
